// ----- hdl/servo_pulse_generator_8ch_defines.svh -----
// Assertion macros used by the checker file spg_checker.sv.
`ifndef SERVO_PULSE_GENERATOR_8CH_DEFINES_SVH
`define SERVO_PULSE_GENERATOR_8CH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spg assertion failed");

`endif

// ----- hdl/spg_pkg.sv -----
`timescale 1ns / 1ps
package spg_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned PIN_W = 8;
  localparam int unsigned CH_W = 3;
  localparam int unsigned US_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [US_W-1:0] FRAME_LEN_RESET = 16'd19000;
  localparam logic [US_W-1:0] PULSE_BASE_RESET = 16'd1000;
  localparam logic signed [US_W:0] MOTOR_CENTER = 17'sd530;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_SET_WIDTH = 2'd1,
    ACT_SET_SPEED = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LEN  = 2'd0,
    CFG_PULSE_BASE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic             frame_start;
  } spg_result_t;

endpackage

// ----- hdl/spg_pin_cmp.sv -----
`timescale 1ns / 1ps
module spg_pin_cmp
  import spg_pkg::*;
(
  input  logic [US_W-1:0]     frame_pos_i,
  input  logic [US_W-1:0]     pulse_base_i,
  input  logic [US_W-1:0]     width_i [CHANNELS],
  input  logic [CHANNELS-1:0] active_i,
  output logic [PIN_W-1:0]    pins_o
);

  always_comb begin
    pins_o = '0;
    for (int k = 0; k < int'(PIN_W); k++) begin
      if (k < int'(CHANNELS)) begin
        pins_o[k] = active_i[k] && (width_i[k] != '0) &&
                    ({1'b0, frame_pos_i} < ({1'b0, pulse_base_i} + {1'b0, width_i[k]}));
      end
    end
  end

endmodule

// ----- hdl/spg_out_fifo.sv -----
`timescale 1ns / 1ps
module spg_out_fifo
  import spg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  spg_result_t push_data_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output spg_result_t out_data_o
);

  spg_result_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/servo_pulse_generator_8ch.sv -----
`timescale 1ns / 1ps
// Eight-channel servo pulse generator. Each input transaction is a one-microsecond
// tick, a set-width command or a motor-speed command, and each one produces exactly
// one result transaction carrying the eight pin levels and a frame-start flag. One
// transaction is accepted every clock cycle while the output buffer is not full; its
// result goes into a two-entry output buffer, so the input keeps accepting while one
// result waits on a stalled output. The cycle time is set by the per-channel
// add-and-compare of the frame position against pulse base plus channel width.
// Configuration writes are always accepted and must be issued only while idle.
module servo_pulse_generator_8ch
  import spg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [CH_W-1:0]      channel_i,
  input  logic [US_W-1:0]      width_us_i,
  input  logic signed [US_W-1:0] speed_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIN_W-1:0]     pins_o,
  output logic                 frame_start_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [US_W-1:0]      cfg_data_i
);

  logic [US_W-1:0]     frame_len_q, frame_len_d;
  logic [US_W-1:0]     pulse_base_q, pulse_base_d;
  logic [US_W-1:0]     frame_pos_q, frame_pos_d;
  logic [US_W-1:0]     chan_width_q [CHANNELS];
  logic [US_W-1:0]     chan_width_d [CHANNELS];
  logic [CHANNELS-1:0] chan_active_q, chan_active_d;

  logic               accept;
  logic               do_set;
  logic [US_W-1:0]    set_value;
  logic signed [US_W:0] half_speed;
  logic signed [US_W:0] motor_width;
  logic [US_W:0]      pos_inc;
  logic [PIN_W-1:0]   pins_new;
  spg_result_t        result;
  spg_result_t        out_data;

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    half_speed  = ($signed({speed_i[US_W-1], speed_i}) +
                   $signed({{US_W{1'b0}}, speed_i[US_W-1]})) >>> 1;
    motor_width = half_speed + MOTOR_CENTER;
  end

  always_comb begin
    do_set    = 1'b0;
    set_value = width_us_i;
    case (action_i)
      ACT_SET_WIDTH: begin
        do_set    = 1'b1;
        set_value = width_us_i;
      end
      ACT_SET_SPEED: begin
        do_set    = 1'b1;
        set_value = motor_width[US_W] ? '0 : motor_width[US_W-1:0];
      end
      default: begin
        do_set = 1'b0;
      end
    endcase
    if (int'(channel_i) >= int'(CHANNELS)) begin
      do_set = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < int'(CHANNELS); k++) begin
      chan_width_d[k] = chan_width_q[k];
    end
    chan_active_d = chan_active_q;
    if (accept && do_set) begin
      for (int k = 0; k < int'(CHANNELS); k++) begin
        if (int'(channel_i) == k) begin
          chan_width_d[k]  = set_value;
          chan_active_d[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    pos_inc     = {1'b0, frame_pos_q} + {{US_W{1'b0}}, 1'b1};
    frame_pos_d = frame_pos_q;
    if (accept && (action_i == ACT_TICK)) begin
      if ((frame_len_q == '0) || (pos_inc >= {1'b0, frame_len_q})) begin
        frame_pos_d = '0;
      end else begin
        frame_pos_d = pos_inc[US_W-1:0];
      end
    end
  end

  always_comb begin
    frame_len_d  = frame_len_q;
    pulse_base_d = pulse_base_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_LEN:  frame_len_d  = cfg_data_i;
        CFG_PULSE_BASE: pulse_base_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  spg_pin_cmp u_pin_cmp (
    .frame_pos_i  (frame_pos_q),
    .pulse_base_i (pulse_base_q),
    .width_i      (chan_width_d),
    .active_i     (chan_active_d),
    .pins_o       (pins_new)
  );

  always_comb begin
    result.pins        = pins_new;
    result.frame_start = (action_i == ACT_TICK) && (frame_pos_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q   <= FRAME_LEN_RESET;
      pulse_base_q  <= PULSE_BASE_RESET;
      frame_pos_q   <= '0;
      chan_active_q <= '0;
      for (int k = 0; k < int'(CHANNELS); k++) begin
        chan_width_q[k] <= '0;
      end
    end else begin
      frame_len_q   <= frame_len_d;
      pulse_base_q  <= pulse_base_d;
      frame_pos_q   <= frame_pos_d;
      chan_active_q <= chan_active_d;
      for (int k = 0; k < int'(CHANNELS); k++) begin
        chan_width_q[k] <= chan_width_d[k];
      end
    end
  end

  spg_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign pins_o        = out_data.pins;
  assign frame_start_o = out_data.frame_start;

endmodule

// ----- hdl/spg_checker.sv -----
`timescale 1ns / 1ps
`include "servo_pulse_generator_8ch_defines.svh"
module spg_checker
  import spg_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [PIN_W-1:0]       pins_o,
  input logic                   frame_start_o
);

  logic             out_held;
  logic             in_take;
  logic [PIN_W:0]   out_word;

  assign out_held = out_valid_o && out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_word = {pins_o, frame_start_o};

  // A stalled result transaction holds its payload.
  `SPG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))

  // The input stalls only when results are pending.
  `SPG_ASSERT_IMP(a_stall_pending, clk_i, rst_ni, in_stall_o, out_valid_o)

  // An accepted transaction into an empty output shows a result next cycle.
  `SPG_ASSERT_NXT(a_result_next, clk_i, rst_ni, in_take && !out_valid_o, out_valid_o)

  // The input stall only rises after a result was held back.
  `SPG_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_held))

endmodule

bind servo_pulse_generator_8ch spg_checker u_spg_checker (.*);

// ----- bench/spg_level_checker.sv -----
`timescale 1ns / 1ps
module spg_level_checker
  import spg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [CH_W-1:0]        channel_i,
  input  logic [US_W-1:0]        width_us_i,
  input  logic signed [US_W-1:0] speed_i,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic [PIN_W-1:0]       pins_o,
  input  logic                   frame_start_o,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [US_W-1:0]        cfg_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  logic [US_W-1:0]     frame_len;
  logic [US_W-1:0]     pulse_base;
  logic [US_W-1:0]     chan_width [CHANNELS];
  logic [CHANNELS-1:0] chan_active;
  logic [US_W-1:0]     frame_pos;
  spg_result_t         levels_due_q [$];
  int unsigned         fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = levels_due_q.size();

  function automatic logic [PIN_W-1:0] servo_levels();
    logic [PIN_W-1:0] lv;
    lv = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (chan_active[k] && chan_width[k] != '0 &&
          {1'b0, frame_pos} < {1'b0, pulse_base} + {1'b0, chan_width[k]}) begin
        lv[k] = 1'b1;
      end
    end
    return lv;
  endfunction

  function automatic spg_result_t servo_step(input logic [1:0] act,
                                             input logic [CH_W-1:0] ch,
                                             input logic [US_W-1:0] w,
                                             input logic signed [US_W-1:0] sp);
    spg_result_t   r;
    int            v;
    logic [US_W:0] nxt;
    r.frame_start = 1'b0;
    if (act == ACT_TICK) begin
      r.frame_start = (frame_pos == '0);
      r.pins = servo_levels();
      nxt = {1'b0, frame_pos} + 1'b1;
      if (frame_len == '0 || nxt >= {1'b0, frame_len}) begin
        nxt = '0;
      end
      frame_pos = nxt[US_W-1:0];
    end else begin
      if (act == ACT_SET_WIDTH) begin
        chan_width[ch] = w;
        chan_active[ch] = 1'b1;
      end else if (act == ACT_SET_SPEED) begin
        v = int'(MOTOR_CENTER) + int'(sp) / 2;
        if (v < 0) begin
          v = 0;
        end
        chan_width[ch] = v[US_W-1:0];
        chan_active[ch] = 1'b1;
      end
      r.pins = servo_levels();
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spg_result_t want;
    if (!rst_ni) begin
      frame_len = FRAME_LEN_RESET;
      pulse_base = PULSE_BASE_RESET;
      for (int k = 0; k < CHANNELS; k++) begin
        chan_width[k] = '0;
      end
      chan_active = '0;
      frame_pos = '0;
      levels_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FRAME_LEN) begin
          frame_len = cfg_data_i;
        end else if (cfg_index_i == CFG_PULSE_BASE) begin
          pulse_base = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        levels_due_q.push_back(servo_step(action_i, channel_i, width_us_i, speed_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (levels_due_q.size() == 0) begin
          if (fails < 10) begin
            $display("Unexpected result transaction: pins %02h frame_start %0b",
                     pins_o, frame_start_o);
          end
          fails++;
        end else begin
          want = levels_due_q.pop_front();
          if (pins_o !== want.pins || frame_start_o !== want.frame_start) begin
            if (fails < 10) begin
              $display("Mismatch at %0t: pins exp %02h got %02h, frame_start exp %0b got %0b",
                       $realtime, want.pins, pins_o, want.frame_start, frame_start_o);
            end
            fails++;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_servo_pulse_generator_8ch.sv -----
`timescale 1ns / 1ps
module tb_servo_pulse_generator_8ch;
  import spg_pkg::*;

  localparam logic [1:0]           ACT_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned          HOLD_CYCLES = 300;
  localparam int unsigned          SEG_ITEMS   = 110;
  localparam int unsigned          SEGMENTS    = 6;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             action = ACT_TICK;
  logic [CH_W-1:0]        channel = '0;
  logic [US_W-1:0]        width_us = '0;
  logic signed [US_W-1:0] speed = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PIN_W-1:0]       pins;
  logic                   frame_start;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_FRAME_LEN;
  logic [US_W-1:0]        cfg_data = '0;

  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 84;
  int unsigned hold_reqs = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #2 clk = ~clk;

  servo_pulse_generator_8ch u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .channel_i    (channel),
    .width_us_i   (width_us),
    .speed_i      (speed),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pins_o       (pins),
    .frame_start_o(frame_start),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  spg_level_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .channel_i    (channel),
    .width_us_i   (width_us),
    .speed_i      (speed),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pins_o       (pins),
    .frame_start_o(frame_start),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : result_stall
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [CH_W-1:0] ch,
                           input logic [US_W-1:0] w, input logic [US_W-1:0] sp);
    int unsigned gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    width_us <= w;
    speed    <= sp;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_random_item();
    int unsigned     sel;
    logic [US_W-1:0] w;
    logic [US_W-1:0] sp;
    sel = $urandom_range(0, 99);
    w = US_W'($urandom);
    sp = US_W'($urandom);
    if (sel < 62) begin
      send_item(ACT_TICK, CH_W'($urandom), w, sp);
    end else if (sel < 80) begin
      if ($urandom_range(0, 9) != 0) begin
        w = US_W'($urandom_range(0, 60));
      end
      send_item(ACT_SET_WIDTH, CH_W'($urandom), w, sp);
    end else if (sel < 95) begin
      case ($urandom_range(0, 2))
        0: sp = 16'(-1061 + int'($urandom_range(0, 140)));
        1: sp = 16'(int'($urandom_range(0, 2000)) - 1200);
        default: ;
      endcase
      send_item(ACT_SET_SPEED, CH_W'($urandom), w, sp);
    end else begin
      send_item(ACT_UNUSED, CH_W'($urandom), w, sp);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic write_random_config();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      write_reg(CFG_FRAME_LEN, 16'd1);
    end else if (sel == 1) begin
      write_reg(CFG_FRAME_LEN, 16'd2);
    end else if (sel == 2) begin
      write_reg(CFG_FRAME_LEN, 16'hFFFF);
    end else begin
      write_reg(CFG_FRAME_LEN, 16'($urandom_range(3, 64)));
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      write_reg(CFG_PULSE_BASE, 16'd0);
    end else if (sel == 1) begin
      write_reg(CFG_PULSE_BASE, 16'hFFFF);
    end else begin
      write_reg(CFG_PULSE_BASE, 16'($urandom_range(0, 40)));
    end
  endtask

  initial begin : stimulus
    int unsigned saved_pct;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);
    send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);
    send_item(ACT_SET_WIDTH, 3'd0, 16'h0000, 16'd0);
    send_item(ACT_SET_WIDTH, 3'd1, 16'hFFFF, 16'd0);
    send_item(ACT_SET_SPEED, 3'd2, 16'd0, 16'h8000);
    send_item(ACT_SET_SPEED, 3'd3, 16'd0, 16'h7FFF);
    send_item(ACT_SET_SPEED, 3'd4, 16'd0, 16'hFFFF);
    send_item(ACT_SET_SPEED, 3'd5, 16'd0, 16'(-1061));
    send_item(ACT_SET_SPEED, 3'd6, 16'd0, 16'(-1062));
    send_item(ACT_SET_SPEED, 3'd7, 16'd0, 16'd1);
    send_item(ACT_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF);
    send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);

    settle();
    write_reg(CFG_FRAME_LEN, 16'd4);
    write_reg(CFG_PULSE_BASE, 16'd0);
    send_item(ACT_SET_WIDTH, 3'd0, 16'd2, 16'd0);
    repeat (5) send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);

    settle();
    write_reg(CFG_FRAME_LEN, 16'd0);
    repeat (2) send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);

    settle();
    write_reg(CFG_FRAME_LEN, 16'hFFFF);
    write_reg(CFG_PULSE_BASE, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'h5A5A);
    send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);

    settle();
    write_reg(CFG_FRAME_LEN, 16'd20);
    write_reg(CFG_PULSE_BASE, 16'd3);
    repeat (6) send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);
    settle();
    write_reg(CFG_FRAME_LEN, 16'd3);
    repeat (2) send_item(ACT_TICK, 3'd0, 16'd0, 16'd0);

    for (int p = 0; p < 3; p++) begin
      settle();
      tx_idle_pct = (p == 0) ? 37 : (p == 1) ? 84 : 0;
      rx_idle_pct = (p == 0) ? 84 : (p == 1) ? 37 : 0;
      write_random_config();
      hold_reqs++;
      saved_pct = tx_idle_pct;
      tx_idle_pct = 0;
      repeat (24) send_random_item();
      tx_idle_pct = saved_pct;
      settle();
      for (int s = 0; s < SEGMENTS; s++) begin
        settle();
        write_random_config();
        repeat (SEG_ITEMS) send_random_item();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input transactions and %0d register writes under three idle patterns,",
             items_sent, cfg_writes);
    $display("with frame lengths from zero to 65535 and long output hold-offs.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_servo_pulse_generator_8ch OK");
    end else begin
      $display("tb_servo_pulse_generator_8ch NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("tb_servo_pulse_generator_8ch NOT OK");
    $finish;
  end

endmodule
